// ----- sv/prrts_pkg.sv -----
package prrts_pkg;

  // default table depth
  localparam int MAX_THREADS_DEF = 16;

  // priority code that create refuses besides zero
  localparam logic [7:0] PRIO_MAX = 8'hFF;

  // wait marks
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_ON   = 2'd1;
  localparam logic [1:0] WAIT_HELD = 2'd2;

  // request codes as they arrive on req_type
  localparam logic [2:0] REQ_CREATE    = 3'd0;
  localparam logic [2:0] REQ_SUSPEND   = 3'd1;
  localparam logic [2:0] REQ_UNSUSPEND = 3'd2;
  localparam logic [2:0] REQ_SLEEP     = 3'd3;
  localparam logic [2:0] REQ_TICK      = 3'd4;
  localparam logic [2:0] REQ_SCHED     = 3'd5;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_SUSPEND,
    OP_UNSUSPEND,
    OP_SLEEP,
    OP_TICK,
    OP_SCHED,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UNS_CUR,
    B_UNS_EV,
    B_TICK_CUR,
    B_TICK_SCAN,
    B_SCH_MAX,
    B_SCH_ROT
  } bstate_t;

  // classified request held between front and back
  typedef struct packed {
    op_t         op;
    logic [4:0]  tid;
    logic [7:0]  prio;
    logic [15:0] ticks;
    logic        atomic;
    logic        prio_bad;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic       status;
    logic [4:0] id;
    logic       yreq;
    logic       woke;
  } res_t;

endpackage

// ----- sv/prrts_front.sv -----
module prrts_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       req_type,
  input  logic [4:0]       target_id,
  input  logic [7:0]       prio_in,
  input  logic [15:0]      sleep_ticks,
  input  logic             atomic_now,
  output logic             q_valid,
  output prrts_pkg::cmd_t  q_cmd,
  input  logic             q_take
);

  prrts_pkg::cmd_t cmd_in;
  prrts_pkg::cmd_t fifo [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fcount;
  logic            do_push;

  // classify the request
  always_comb begin
    cmd_in.tid      = target_id;
    cmd_in.prio     = prio_in;
    cmd_in.ticks    = sleep_ticks;
    cmd_in.atomic   = atomic_now;
    cmd_in.prio_bad = (prio_in == 8'd0) || (prio_in == prrts_pkg::PRIO_MAX);
    case (req_type)
      prrts_pkg::REQ_CREATE:    cmd_in.op = prrts_pkg::OP_CREATE;
      prrts_pkg::REQ_SUSPEND:   cmd_in.op = prrts_pkg::OP_SUSPEND;
      prrts_pkg::REQ_UNSUSPEND: cmd_in.op = prrts_pkg::OP_UNSUSPEND;
      prrts_pkg::REQ_SLEEP:     cmd_in.op = prrts_pkg::OP_SLEEP;
      prrts_pkg::REQ_TICK:      cmd_in.op = prrts_pkg::OP_TICK;
      prrts_pkg::REQ_SCHED:     cmd_in.op = prrts_pkg::OP_SCHED;
      default:                  cmd_in.op = prrts_pkg::OP_BAD;
    endcase
  end

  assign full    = (fcount == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (fcount != 2'd0);
  assign q_cmd   = fifo[rd_ptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= cmd_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fcount <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (q_take)  rd_ptr <= !rd_ptr;
      case ({do_push, q_take})
        2'b10:   fcount <= fcount + 2'd1;
        2'b01:   fcount <= fcount - 2'd1;
        default: fcount <= fcount;
      endcase
    end
  end

endmodule

// ----- sv/prrts_back.sv -----
module prrts_back #(
  parameter int MAX_THREADS = prrts_pkg::MAX_THREADS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  prrts_pkg::cmd_t  q_cmd,
  output logic             q_take,
  input  logic             res_full,
  output logic             res_valid,
  output prrts_pkg::res_t  res
);

  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int SW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TW = (CW > 5) ? CW : 5;

  prrts_pkg::bstate_t state, state_next;

  // thread table
  logic [MAX_THREADS-1:0] ready;
  logic [MAX_THREADS-1:0] lrm;
  logic [1:0]             wm [MAX_THREADS];
  logic [7:0]             prio_mem [MAX_THREADS];
  logic [15:0]            wake_mem [MAX_THREADS];
  logic [15:0]            tick;
  logic [CW-1:0]          count;
  logic [CW-1:0]          cur;
  logic                   running;

  // working registers
  prrts_pkg::cmd_t cmd;
  logic [SW-1:0]   rd_addr;
  logic [7:0]      rd_prio;
  logic [15:0]     rd_wake;
  logic [CW-1:0]   idx;
  logic            ev_vld;
  logic [SW-1:0]   ev_idx;
  logic [7:0]      cur_prio;
  logic [7:0]      maxp;
  logic [SW-1:0]   first;
  logic            have;
  logic [SW-1:0]   cand;
  logic            cand_v;
  logic            yreq;
  logic            woke;

  // shared decode
  logic [TW-1:0] cnt_w;
  logic [CW-1:0] sus_id;
  logic          sus_ok, uns_ok, slp_ok, crt_ok, cur_ok;
  logic [SW-1:0] cur_slot, chosen;
  logic [16:0]   wake_sum;
  logic [15:0]   tick_inc;
  logic          issue, scan_end, in_scan, start;

  assign cnt_w    = TW'(count);
  assign cur_ok   = (cur != '0) && (cur <= count);
  assign cur_slot = SW'(cur - CW'(1));
  assign chosen   = (have && cand_v) ? cand : first;
  assign wake_sum = {1'b0, tick} + {1'b0, q_cmd.ticks};
  assign tick_inc = tick + 16'd1;
  assign in_scan  = (state == prrts_pkg::B_TICK_SCAN) || (state == prrts_pkg::B_SCH_MAX) ||
                    (state == prrts_pkg::B_SCH_ROT);
  assign issue    = in_scan && (idx < count);
  assign scan_end = (idx >= count) && !ev_vld;
  assign start    = q_take;

  // checks on the request at the head of the queue
  always_comb begin
    logic [TW-1:0] qt;
    qt     = TW'(q_cmd.tid);
    sus_id = (q_cmd.tid == 5'd0) ? cur : CW'(q_cmd.tid);
    sus_ok = (qt <= cnt_w) && (sus_id != '0) && (sus_id <= count);
    uns_ok = (q_cmd.tid != 5'd0) && (qt <= cnt_w);
    slp_ok = running && cur_ok;
    crt_ok = !q_cmd.prio_bad && !running && (count < CW'(MAX_THREADS));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= prrts_pkg::B_IDLE;
    else     state <= state_next;
  end

  // sequencer: next state, read address, result
  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    rd_addr    = SW'(idx);
    case (state)
      prrts_pkg::B_IDLE: begin
        rd_addr = cur_slot;
        if (q_valid && !res_full) begin
          q_take = 1'b1;
          case (q_cmd.op)
            prrts_pkg::OP_CREATE: begin
              res_valid  = 1'b1;
              res.status = !crt_ok;
              res.id     = crt_ok ? 5'(count + CW'(1)) : 5'd0;
            end
            prrts_pkg::OP_SUSPEND: begin
              res_valid  = 1'b1;
              res.status = !sus_ok;
              res.yreq   = sus_ok && (sus_id == cur) && !q_cmd.atomic && running;
            end
            prrts_pkg::OP_UNSUSPEND: begin
              if (uns_ok) begin
                state_next = prrts_pkg::B_UNS_CUR;
              end else begin
                res_valid  = 1'b1;
                res.status = 1'b1;
              end
            end
            prrts_pkg::OP_SLEEP: begin
              res_valid  = 1'b1;
              res.status = !slp_ok;
              res.yreq   = slp_ok;
            end
            prrts_pkg::OP_TICK: begin
              if (running) state_next = prrts_pkg::B_TICK_CUR;
              else         res_valid  = 1'b1;
            end
            prrts_pkg::OP_SCHED: begin
              state_next = prrts_pkg::B_SCH_MAX;
            end
            default: begin
              res_valid  = 1'b1;
              res.status = 1'b1;
            end
          endcase
        end
      end
      prrts_pkg::B_UNS_CUR: begin
        rd_addr    = SW'(cmd.tid - 5'd1);
        state_next = prrts_pkg::B_UNS_EV;
      end
      prrts_pkg::B_UNS_EV: begin
        res_valid  = 1'b1;
        res.yreq   = running && !cmd.atomic && (rd_prio > cur_prio);
        state_next = prrts_pkg::B_IDLE;
      end
      prrts_pkg::B_TICK_CUR: begin
        state_next = prrts_pkg::B_TICK_SCAN;
      end
      prrts_pkg::B_TICK_SCAN: begin
        if (scan_end) begin
          res_valid  = 1'b1;
          res.yreq   = yreq;
          res.woke   = woke;
          state_next = prrts_pkg::B_IDLE;
        end
      end
      prrts_pkg::B_SCH_MAX: begin
        if (scan_end) begin
          if (maxp == 8'd0) begin
            res_valid  = 1'b1;
            state_next = prrts_pkg::B_IDLE;
          end else begin
            state_next = prrts_pkg::B_SCH_ROT;
          end
        end
      end
      prrts_pkg::B_SCH_ROT: begin
        if (scan_end) begin
          res_valid  = 1'b1;
          res.id     = 5'({1'b0, chosen} + (SW + 1)'(1));
          state_next = prrts_pkg::B_IDLE;
        end
      end
      default: state_next = prrts_pkg::B_IDLE;
    endcase
  end

  // priority and wake time stores, one read port
  always_ff @(posedge clk) begin
    rd_prio <= prio_mem[rd_addr];
    rd_wake <= wake_mem[rd_addr];
    if (start && (q_cmd.op == prrts_pkg::OP_CREATE) && crt_ok) begin
      prio_mem[SW'(count)] <= q_cmd.prio;
      wake_mem[SW'(count)] <= 16'd0;
    end else if (start && (q_cmd.op == prrts_pkg::OP_SLEEP) && slp_ok) begin
      wake_mem[cur_slot] <= wake_sum[15:0];
    end
  end

  // scan pipeline and scratch registers
  always_ff @(posedge clk) begin
    ev_idx <= SW'(idx);
    if (start) begin
      cmd    <= q_cmd;
      maxp   <= 8'd0;
      first  <= '0;
      yreq   <= 1'b0;
      woke   <= 1'b0;
      have   <= 1'b0;
      cand_v <= 1'b0;
    end
    if ((state == prrts_pkg::B_UNS_CUR) || (state == prrts_pkg::B_TICK_CUR)) begin
      cur_prio <= cur_ok ? rd_prio : 8'd0;
    end
    if (ev_vld) begin
      case (state)
        prrts_pkg::B_TICK_SCAN: begin
          if ((wm[ev_idx] == prrts_pkg::WAIT_ON) && (rd_wake <= tick)) begin
            woke <= 1'b1;
            if (!cmd.atomic && (rd_prio > cur_prio)) yreq <= 1'b1;
          end
        end
        prrts_pkg::B_SCH_MAX: begin
          if (ready[ev_idx] && (rd_prio > maxp)) begin
            maxp  <= rd_prio;
            first <= ev_idx;
          end
        end
        prrts_pkg::B_SCH_ROT: begin
          if (ready[ev_idx] && (rd_prio == maxp)) begin
            if (lrm[ev_idx]) begin
              have   <= 1'b1;
              cand_v <= 1'b0;
            end else if (have && !cand_v) begin
              cand   <= ev_idx;
              cand_v <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (rst) begin
      idx    <= '0;
      ev_vld <= 1'b0;
    end else begin
      ev_vld <= issue;
      if (issue)         idx <= idx + CW'(1);
      else if (scan_end) idx <= '0;
      if (start)         idx <= '0;
    end
  end

  // thread table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      ready   <= '0;
      lrm     <= '0;
      for (int i = 0; i < MAX_THREADS; i++) wm[i] <= prrts_pkg::WAIT_NONE;
      tick    <= 16'd0;
      count   <= '0;
      cur     <= '0;
      running <= 1'b0;
    end else begin
      if (start) begin
        case (q_cmd.op)
          prrts_pkg::OP_CREATE: begin
            if (crt_ok) begin
              ready[SW'(count)] <= 1'b1;
              lrm[SW'(count)]   <= 1'b0;
              wm[SW'(count)]    <= prrts_pkg::WAIT_NONE;
              count             <= count + CW'(1);
            end
          end
          prrts_pkg::OP_SUSPEND: begin
            if (sus_ok) ready[SW'(sus_id - CW'(1))] <= 1'b0;
          end
          prrts_pkg::OP_SLEEP: begin
            if (slp_ok) begin
              ready[cur_slot] <= 1'b0;
              wm[cur_slot]    <= wake_sum[16] ? prrts_pkg::WAIT_HELD : prrts_pkg::WAIT_ON;
            end
          end
          prrts_pkg::OP_TICK: begin
            if (running) begin
              tick <= tick_inc;
              // tick wrap releases held sleepers
              if (tick_inc == 16'd0) begin
                for (int i = 0; i < MAX_THREADS; i++) begin
                  if ((CW'(i) < count) && (wm[i] == prrts_pkg::WAIT_HELD)) begin
                    wm[i] <= prrts_pkg::WAIT_ON;
                  end
                end
              end
            end
          end
          prrts_pkg::OP_SCHED: running <= 1'b1;
          default: ;
        endcase
      end
      // unsuspend completes
      if (state == prrts_pkg::B_UNS_EV) begin
        ready[SW'(cmd.tid - 5'd1)] <= 1'b1;
      end
      // woken sleeper
      if (ev_vld && (state == prrts_pkg::B_TICK_SCAN) &&
          (wm[ev_idx] == prrts_pkg::WAIT_ON) && (rd_wake <= tick)) begin
        ready[ev_idx] <= 1'b1;
      end
      // clear last-run marks at the chosen priority
      if (ev_vld && (state == prrts_pkg::B_SCH_ROT) && (rd_prio == maxp)) begin
        lrm[ev_idx] <= 1'b0;
      end
      if ((state == prrts_pkg::B_SCH_MAX) && scan_end && (maxp == 8'd0)) begin
        cur <= '0;
      end
      if ((state == prrts_pkg::B_SCH_ROT) && scan_end) begin
        lrm[chosen] <= 1'b1;
        wm[chosen]  <= prrts_pkg::WAIT_NONE;
        cur         <= CW'({1'b0, chosen} + (SW + 1)'(1));
      end
    end
  end

endmodule

// ----- sv/priority_round_robin_thread_scheduler.sv -----
// Channel   Handshake              Payload
// request   push / full            req_type target_id prio_in sleep_ticks atomic_now
// result    empty / pop            status id_out yield_request woke_any
//
// Create, suspend, sleep and refused requests finish in the back end's idle state; unsuspend
// goes on through B_UNS_CUR and B_UNS_EV. A running tick scans the table once and schedule twice,
// all through the one read port of the priority and wake time stores (one entry per cycle).
// A two-entry request queue and a one-entry result register decouple both sides.
// The back end starts a request only while the result register is free.
// Reset (rst, synchronous) clears the table flags, counters and both queues.
module priority_round_robin_thread_scheduler #(
  parameter int MAX_THREADS = prrts_pkg::MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [4:0]  target_id,
  input  logic [7:0]  prio_in,
  input  logic [15:0] sleep_ticks,
  input  logic        atomic_now,
  output logic        empty,
  input  logic        pop,
  output logic        status,
  output logic [4:0]  id_out,
  output logic        yield_request,
  output logic        woke_any
);

  logic            q_valid;
  prrts_pkg::cmd_t q_cmd;
  logic            q_take;
  logic            res_valid;
  prrts_pkg::res_t res;
  logic            out_valid;
  prrts_pkg::res_t out_res;

  prrts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .target_id   (target_id),
    .prio_in     (prio_in),
    .sleep_ticks (sleep_ticks),
    .atomic_now  (atomic_now),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_take      (q_take)
  );

  prrts_back #(
    .MAX_THREADS (MAX_THREADS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_take    (q_take),
    .res_full  (out_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (res_valid) out_res <= res;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty         = !out_valid;
  assign status        = out_res.status;
  assign id_out        = out_res.id;
  assign yield_request = out_res.yreq;
  assign woke_any      = out_res.woke;

`ifndef SYNTHESIS
  // back end never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_valid) else $error("result overwritten");

  // a refused transaction carries no id and no wake report
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (id_out == 5'd0 && !woke_any)) else $error("dirty error result");

  // popped result leaves the register empty when nothing new finishes
  a_pop_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !res_valid) |=> empty) else $error("pop did not drain");
`endif

endmodule

// ----- sim/priority_round_robin_thread_scheduler_test.sv -----
`timescale 1ns / 100ps

module priority_round_robin_thread_scheduler_test;

  localparam int NTHR = 16;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [2:0]  req;
    logic [4:0]  tid;
    logic [7:0]  prio;
    logic [15:0] ticks;
    logic        atomic;
  } request_t;

  typedef struct {
    logic       status;
    logic [4:0] id;
    logic       yreq;
    logic       woke;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [2:0]  req_type = '0;
  logic [4:0]  target_id = '0;
  logic [7:0]  prio_in = '0;
  logic [15:0] sleep_ticks = '0;
  logic        atomic_now = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, status, yield_request, woke_any;
  logic [4:0]  id_out;

  priority_round_robin_thread_scheduler u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .target_id(target_id), .prio_in(prio_in),
    .sleep_ticks(sleep_ticks), .atomic_now(atomic_now),
    .empty(empty), .pop(pop), .status(status), .id_out(id_out),
    .yield_request(yield_request), .woke_any(woke_any)
  );

  always #1 clk = ~clk;

  // shadow thread table
  logic        sh_ready [NTHR];
  logic [7:0]  sh_prio  [NTHR];
  logic        sh_last  [NTHR];
  logic [1:0]  sh_wait  [NTHR];
  logic [15:0] sh_wake  [NTHR];
  logic [15:0] sh_tick;
  int          sh_count;
  int          sh_cur;
  logic        sh_run;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  bit       stim_done = 0;

  function automatic int cur_prio();
    if (sh_cur == 0 || sh_cur > sh_count) return 0;
    return sh_prio[sh_cur-1];
  endfunction

  function automatic int pick_thread();
    int maxp, first, last;
    bit have;
    maxp = 0; first = 0; last = 0; have = 0;
    for (int i = 0; i < sh_count; i++)
      if (sh_ready[i] && sh_prio[i] > maxp) begin
        maxp = sh_prio[i];
        first = i;
      end
    if (maxp == 0) return 0;
    for (int i = 0; i < sh_count; i++)
      if (sh_ready[i] && sh_prio[i] == maxp && sh_last[i]) begin
        last = i;
        have = 1;
      end
    if (have)
      for (int i = last + 1; i < sh_count; i++)
        if (sh_ready[i] && sh_prio[i] == maxp) return i + 1;
    return first + 1;
  endfunction

  // compute the outcome of one request and update the shadow table
  function automatic outcome_t schedule_outcome(request_t r);
    outcome_t o;
    int id;
    logic [16:0] sum;
    logic [7:0] p;
    o = '{1'b0, 5'd0, 1'b0, 1'b0};
    case (r.req)
      prrts_pkg::REQ_CREATE: begin
        if (r.prio == 0 || r.prio == prrts_pkg::PRIO_MAX || sh_run || sh_count >= NTHR) begin
          o.status = 1;
        end else begin
          sh_ready[sh_count] = 1;
          sh_prio[sh_count] = r.prio;
          sh_last[sh_count] = 0;
          sh_wait[sh_count] = prrts_pkg::WAIT_NONE;
          sh_wake[sh_count] = 0;
          sh_count++;
          o.id = 5'(sh_count);
        end
      end
      prrts_pkg::REQ_SUSPEND: begin
        id = (r.tid == 0) ? sh_cur : r.tid;
        if (r.tid > sh_count || id == 0 || id > sh_count) begin
          o.status = 1;
        end else begin
          sh_ready[id-1] = 0;
          o.yreq = (id == sh_cur) && !r.atomic && sh_run;
        end
      end
      prrts_pkg::REQ_UNSUSPEND: begin
        if (r.tid == 0 || r.tid > sh_count) begin
          o.status = 1;
        end else begin
          sh_ready[r.tid-1] = 1;
          o.yreq = sh_run && !r.atomic && sh_prio[r.tid-1] > cur_prio();
        end
      end
      prrts_pkg::REQ_SLEEP: begin
        if (!sh_run || sh_cur == 0 || sh_cur > sh_count) begin
          o.status = 1;
        end else begin
          sum = {1'b0, sh_tick} + {1'b0, r.ticks};
          sh_wake[sh_cur-1] = sum[15:0];
          sh_wait[sh_cur-1] = sum[16] ? prrts_pkg::WAIT_HELD : prrts_pkg::WAIT_ON;
          sh_ready[sh_cur-1] = 0;
          o.yreq = 1;
        end
      end
      prrts_pkg::REQ_TICK: begin
        if (sh_run) begin
          sh_tick++;
          if (sh_tick == 0)
            for (int i = 0; i < sh_count; i++)
              if (sh_wait[i] == prrts_pkg::WAIT_HELD) sh_wait[i] = prrts_pkg::WAIT_ON;
          for (int i = 0; i < sh_count; i++)
            if (sh_wait[i] == prrts_pkg::WAIT_ON && sh_wake[i] <= sh_tick) begin
              sh_ready[i] = 1;
              if (!r.atomic && sh_prio[i] > cur_prio()) o.yreq = 1;
              o.woke = 1;
            end
        end
      end
      prrts_pkg::REQ_SCHED: begin
        sh_run = 1;
        id = pick_thread();
        sh_cur = id;
        if (id != 0) begin
          p = sh_prio[id-1];
          for (int i = 0; i < sh_count; i++)
            if (sh_prio[i] == p) sh_last[i] = 0;
          sh_last[id-1] = 1;
          sh_wait[id-1] = prrts_pkg::WAIT_NONE;
        end
        o.id = 5'(id);
      end
      default: o.status = 1;
    endcase
    return o;
  endfunction

  function automatic request_t make_req(logic [2:0] q, int t, int p, int k, bit a);
    request_t r;
    r.req = q; r.tid = 5'(t); r.prio = 8'(p); r.ticks = 16'(k); r.atomic = a;
    return r;
  endfunction

  // random request with random content, weighted toward a running scheduler
  function automatic request_t random_req(int nthreads);
    request_t r;
    int w;
    r.req = prrts_pkg::REQ_SCHED;
    r.tid = 5'($urandom_range(0, nthreads + 1));
    if ($urandom_range(0, 15) == 0) r.tid = 5'($urandom_range(0, 31));
    r.prio = 8'($urandom_range(1, 6));
    if ($urandom_range(0, 7) == 0) r.prio = 8'($urandom);
    case ($urandom_range(0, 3))
      0: r.ticks = 16'($urandom_range(0, 4));
      1: r.ticks = 16'($urandom_range(0, 20));
      2: r.ticks = 16'($urandom);
      default: r.ticks = 16'hFFFF - 16'($urandom_range(0, 3));
    endcase
    r.atomic = ($urandom_range(0, 3) == 0);
    w = $urandom_range(0, 99);
    if (w < 12) r.req = prrts_pkg::REQ_SUSPEND;
    else if (w < 26) r.req = prrts_pkg::REQ_UNSUSPEND;
    else if (w < 36) r.req = prrts_pkg::REQ_SLEEP;
    else if (w < 70) r.req = prrts_pkg::REQ_TICK;
    else if (w < 96) r.req = prrts_pkg::REQ_SCHED;
    else if (w < 98) r.req = prrts_pkg::REQ_CREATE;
    else r.req = 3'($urandom_range(6, 7));
    return r;
  endfunction

  // stimulus: directed start, then sessions separated by nothing (reset once)
  initial begin
    int n, total;
    pending_reqs.push_back(make_req(prrts_pkg::REQ_TICK, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SUSPEND, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SLEEP, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, 255, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 31, 1, 16'hFFFF, 1));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, 254, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, 254, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_UNSUSPEND, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_UNSUSPEND, 31, 0, 0, 0));
    pending_reqs.push_back(make_req(3'd6, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(3'd7, 31, 255, 16'hFFFF, 1));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, 5, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SLEEP, 0, 0, 16'hFFFF, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SUSPEND, 2, 0, 0, 1));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SUSPEND, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_SCHED, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_UNSUSPEND, 3, 0, 0, 0));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_UNSUSPEND, 2, 0, 0, 1));
    pending_reqs.push_back(make_req(prrts_pkg::REQ_TICK, 0, 0, 0, 0));
    total = 0;
    n = 3;
    // these creates follow a schedule and are refused, so the table keeps its three threads
    for (int k = 0; k < 13; k++) begin
      pending_reqs.push_back(make_req(prrts_pkg::REQ_CREATE, 0, $urandom_range(1, 254), 0, 0));
      n++;
    end
    while (total < 310) begin
      pending_reqs.push_back(random_req(n));
      total++;
    end
    // long tick run to wake sleepers
    for (int k = 0; k < 300; k++)
      pending_reqs.push_back(make_req(($urandom_range(0, 9) == 0) ? prrts_pkg::REQ_SCHED :
                                      prrts_pkg::REQ_TICK, 0, 0, 0,
                                      1'($urandom_range(0, 1))));
    stim_done = 1;
  end

  initial begin
    for (int i = 0; i < NTHR; i++) begin
      sh_ready[i] = 0; sh_prio[i] = 0; sh_last[i] = 0; sh_wait[i] = prrts_pkg::WAIT_NONE;
      sh_wake[i] = 0;
    end
    sh_tick = 0; sh_count = 0; sh_cur = 0; sh_run = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: bursts of transactions with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        r.req = req_type; r.tid = target_id; r.prio = prio_in;
        r.ticks = sleep_ticks; r.atomic = atomic_now;
        expected_outcomes.push_back(schedule_outcome(r));
      end
      if (push && full) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        push <= 1'b1;
        req_type <= r.req; target_id <= r.tid; prio_in <= r.prio;
        sleep_ticks <= r.ticks; atomic_now <= r.atomic;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: receiver stalls on its own pattern, checks each result
  int stall_phase = 0;
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%0d", $time, status, id_out);
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status);
            errors++;
          end
          if (id_out !== e.id) begin
            $display("%0t: id_out expected %0d actual %0d", $time, e.id, id_out);
            errors++;
          end
          if (yield_request !== e.yreq) begin
            $display("%0t: yield_request expected %0d actual %0d", $time, e.yreq,
                     yield_request);
            errors++;
          end
          if (woke_any !== e.woke) begin
            $display("%0t: woke_any expected %0d actual %0d", $time, e.woke, woke_any);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 200) pop <= 1'b1;
      else if (stall_phase < 400) pop <= ($urandom_range(0, 3) != 0);
      else pop <= ((stall_phase % 7) < 3) && ($urandom_range(0, 1) == 1);
    end
  end

  // watchdog and end of run
  int idle_cycles = 0;
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (stim_done && pending_reqs.size() == 0 && !push &&
          expected_outcomes.size() == 0) begin
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_outcomes.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
sv/prrts_pkg.sv
sv/prrts_front.sv
sv/prrts_back.sv
sv/priority_round_robin_thread_scheduler.sv
sim/priority_round_robin_thread_scheduler_test.sv
